/* design/u2l_pkg.sv */
// Package for the UTF-8 to Latin-1 fold block: item types, byte classes and
// the fold tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package u2l_pkg;

  localparam int unsigned CountW = 16;

  localparam logic [511:0] Tab0 =
    "AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGgGgGgHhHhIiIiIiIiIiiiJjKkkLlLlLlL";
  localparam logic [511:0] Tab1 =
    "lLlNnNnNnnNnOoOoOoOoRrRrRrSsSsSsSsTtTtTtUuUuUuUuUuUuWwYyYZzZzZzs";
  localparam logic [511:0] Tab2 =
    "bBBbbbCCcDDDddEaEFfGGhIIKkllWNnOCoOoPpRS2EetTttUuUVYyZzEEee255?w";
  localparam logic [511:0] Tab3 =
    "||||DDdLLlNNnAaIiOoUuUuUuUuUueAaAaAaGgGgKkOoOoEejDDdGgHWNnAaAaOo";

  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChStar  = 8'h2A;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            last;
  } job_t;

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      n;
  } fold_t;

  function automatic logic [2:0] seq_need(input logic [7:0] x);
    logic [2:0] r;
    if ((x & 8'hF8) == 8'hF0) r = 3'd4;
    else if ((x & 8'hF0) == 8'hE0) r = 3'd3;
    else if ((x & 8'hE0) == 8'hC0 && x >= 8'hC2) r = 3'd2;
    else r = 3'd1;
    return r;
  endfunction

  function automatic logic is_cont(input logic [7:0] x);
    return (x & 8'hC0) == 8'h80;
  endfunction

  function automatic logic [7:0] tab_char(input logic [1:0] row, input logic [5:0] col);
    logic [8:0] base;
    logic [7:0] r;
    base = {~col, 3'b000};
    unique case (row)
      2'd0: r = Tab0[base +: 8];
      2'd1: r = Tab1[base +: 8];
      2'd2: r = Tab2[base +: 8];
      default: r = Tab3[base +: 8];
    endcase
    return r;
  endfunction

  function automatic fold_t one(input logic [7:0] c);
    fold_t f;
    f = '0;
    f.b[0] = c;
    f.n = 2'd1;
    return f;
  endfunction

  function automatic fold_t fold2(input logic [7:0] b0, input logic [7:0] b1);
    fold_t f;
    f = '0;
    if (b0 == 8'hC2) begin
      if (b1 != 8'hAD) f = one((b1 == 8'hA0) ? ChSpace : b1);
    end else if (b0 == 8'hC3) begin
      f = one(b1 + 8'h40);
    end else if (b0 >= 8'hC4 && b0 <= 8'hC7) begin
      f = one(tab_char(b0[1:0], b1[5:0]));
    end else if (b0 == 8'hCC || (b0 == 8'hCD && b1 <= 8'hAF)) begin
      f = '0;
    end else begin
      f = one(ChQuest);
    end
    return f;
  endfunction

  function automatic fold_t fold3(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2);
    fold_t f;
    logic [15:0] cp;
    f = '0;
    cp = {b0[3:0], b1[5:0], b2[5:0]};
    if (b0 == 8'hE2 && b1 == 8'h80) begin
      unique case (b2)
        8'h8A, 8'hAF: f = one(ChSpace);
        8'h93: f = one(ChDash);
        8'h94: begin
          f.b[0] = ChDash;
          f.b[1] = ChDash;
          f.n = 2'd2;
        end
        8'h98: f = one(8'h60);
        8'h99: f = one(8'h27);
        8'h9C, 8'h9D: f = one(8'h22);
        8'hA6: begin
          f.b[0] = ChDot;
          f.b[1] = ChDot;
          f.b[2] = ChDot;
          f.n = 2'd3;
        end
        default: f = one(ChQuest);
      endcase
    end else if (b0 == 8'hE2 && b1 == 8'h96) begin
      f = one((b2 == 8'h88) ? ChStar : ChQuest);
    end else if (cp == 16'h2122) begin
      f.b[0] = 8'h54;
      f.b[1] = 8'h4D;
      f.n = 2'd2;
    end else if (cp == 16'h00A0) begin
      f = one(ChSpace);
    end else if (cp >= 16'h0080 && cp <= 16'h00FF) begin
      f = one(cp[7:0]);
    end else begin
      f = one(ChQuest);
    end
    return f;
  endfunction

endpackage
`default_nettype wire

/* design/u2l_decode.sv */
// Sequence decoder: holds pending lead/continuation bytes and turns each item
// into a list of up to four candidate output bytes. Uses u2l_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u2l_decode import u2l_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       is_last_i,
  output job_t            job_o
);

  logic [2:0][7:0] pb_q, pb_d;
  logic [1:0]      pcnt_q, pcnt_d;

  always_comb begin
    logic [2:0]  n_lead;
    logic        cb;
    logic        fresh;
    logic [1:0]  rawn;
    fold_t       t;
    logic [1:0]  ti;
    n_lead = seq_need(pb_q[0]);
    cb     = is_cont(in_byte_i);
    pb_d   = pb_q;
    pcnt_d = 2'd0;
    rawn   = 2'd0;
    fresh  = 1'b0;
    t      = '0;
    if (pcnt_q == 2'd0 || !cb) begin
      fresh = 1'b1;
      rawn  = pcnt_q;
    end else if ({1'b0, pcnt_q} + 3'd1 == n_lead) begin
      if (n_lead == 3'd4) t = one(ChQuest);
      else if (n_lead == 3'd3) t = fold3(pb_q[0], pb_q[1], in_byte_i);
      else t = fold2(pb_q[0], in_byte_i);
    end else if (is_last_i) begin
      rawn = pcnt_q;
      t    = one(in_byte_i);
    end else begin
      pb_d[pcnt_q] = in_byte_i;
      pcnt_d       = pcnt_q + 2'd1;
    end
    if (fresh) begin
      if (seq_need(in_byte_i) != 3'd1 && !is_last_i) begin
        pb_d[0] = in_byte_i;
        pcnt_d  = 2'd1;
      end else begin
        t = one(in_byte_i);
      end
    end
    if (is_last_i) pcnt_d = 2'd0;
    job_o.bytes = '0;
    for (int i = 0; i < 4; i++) begin
      ti = 2'(i) - rawn;
      if (2'(i) < rawn && i < 3) job_o.bytes[i] = pb_q[2'(i)];
      else if (ti < 2'd3) job_o.bytes[i] = t.b[ti];
    end
    job_o.cnt  = {1'b0, rawn} + {1'b0, t.n};
    job_o.last = is_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= 2'd0;
    end else if (accept_i) begin
      pcnt_q <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pb_q <= pb_d;
    end
  end

endmodule
`default_nettype wire

/* design/utf8_to_latin1_fold_top.sv */
// Latency: an item's first result is offered the cycle after it is accepted.
// Throughput: one item per cycle while each item gives at most one result and the
// output is not stalled; an item giving more holds the job register and stalls input
// until its last result is taken. Capacity checks happen as each byte leaves the job register.
// Reset clears pending count, written count, job valid; capacity to 65535.
// Top level of the UTF-8 to Latin-1 fold block. Uses u2l_pkg, u2l_decode.
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_latin1_fold_top import u2l_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CountW-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              is_last_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   has_byte_o,
  output logic                   run_end_o,
  output logic                   string_end_o,
  output logic [CountW-1:0]      total_written_o
);

  job_t              dec_job;
  job_t              job_q;
  logic              job_v_q;
  logic [2:0]        idx_q;
  logic [CountW-1:0] wc_q, cap_q;
  logic              accept, fire, emit_byte, more_after, job_done, wr_ok;

  u2l_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .is_last_i (is_last_i),
    .job_o     (dec_job)
  );

  assign cfg_ready_o = 1'b1;
  assign wr_ok       = ({1'b0, wc_q} + 17'd1) < {1'b0, cap_q};
  assign emit_byte   = (idx_q < job_q.cnt) && wr_ok;
  assign more_after  = emit_byte &&
                       (((idx_q + 3'd1 < job_q.cnt) &&
                         ({2'b00, wc_q} + 18'd2 < {2'b00, cap_q})) || job_q.last);
  assign out_valid_o = job_v_q && (emit_byte || job_q.last);
  assign fire        = out_valid_o && !out_stall_i;
  assign job_done    = job_v_q && (!out_valid_o || (fire && !more_after));
  assign in_stall_o  = job_v_q && !job_done;
  assign accept      = in_valid_i && !in_stall_o;

  assign out_byte_o      = emit_byte ? job_q.bytes[idx_q[1:0]] : 8'h00;
  assign has_byte_o      = emit_byte;
  assign run_end_o       = !more_after;
  assign string_end_o    = !emit_byte;
  assign total_written_o = emit_byte ? '0 : wc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      idx_q   <= 3'd0;
      wc_q    <= '0;
      cap_q   <= 16'hFFFF;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
      if (fire) begin
        if (emit_byte) begin
          wc_q <= wc_q + 16'd1;
        end else begin
          wc_q <= '0;
        end
      end
      if (accept) begin
        job_v_q <= (dec_job.cnt != 3'd0) || dec_job.last;
        idx_q   <= 3'd0;
      end else begin
        if (fire && emit_byte) idx_q <= idx_q + 3'd1;
        if (job_done) job_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) job_q <= dec_job;
  end

`ifndef SYNTHESIS
  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> !has_byte_o && run_end_o)
    else $error("marker item carries a byte or is not last");
  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && string_end_o |=> wc_q == '0)
    else $error("written count not cleared after marker");
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_byte_o |-> ({1'b0, wc_q} + 17'd1) < {1'b0, cap_q})
    else $error("byte emitted beyond capacity");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> job_v_q)
    else $error("input stalled with no job held");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for utf8_to_latin1_fold_top: directed strings, then
// random UTF-8 strings over several capacities, with random stalls on both sides.
// Depends on u2l_pkg (CountW) and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
  import u2l_pkg::*;

  typedef struct {
    logic [7:0]        ch;
    logic              has;
    logic              run_end;
    logic              str_end;
    logic [CountW-1:0] total;
  } fold_res_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    int         total;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CountW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [7:0] in_byte_i = '0;
  logic is_last_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic cfg_ready_o, in_stall_o, out_valid_o, has_byte_o, run_end_o, string_end_o;
  logic [7:0] out_byte_o;
  logic [CountW-1:0] total_written_o;

  utf8_to_latin1_fold_top uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]        held_bytes[3];
  int                held_cnt;
  int                written;
  logic [CountW-1:0] capacity;
  fold_res_t         step_res[$];
  fold_res_t         expected_out[$];

  string ext_rows[4] = '{
    "AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGgGgGgHhHhIiIiIiIiIiiiJjKkkLlLlLlL",
    "lLlNnNnNnnNnOoOoOoOoRrRrRrSsSsSsSsTtTtTtUuUuUuUuUuUuWwYyYZzZzZzs",
    "bBBbbbCCcDDDddEaEFfGGhIIKkllWNnOCoOoPpRS2EetTttUuUVYyZzEEee255?w",
    "||||DDdLLlNNnAaIiOoUuUuUuUuUueAaAaAaGgGgKkOoOoEejDDdGgHWNnAaAaOo"};

  int  errors = 0;
  int  strings_sent = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  function automatic void emit(logic [7:0] c);
    fold_res_t r;
    if (written + 1 < int'(capacity) && written < 65535) begin
      written++;
      r = '{c, 1'b1, 1'b0, 1'b0, '0};
      step_res.push_back(r);
    end
  endfunction

  function automatic void fold_pair(logic [7:0] b0, logic [7:0] b1);
    if (b0 == 8'hC2) begin
      if (b1 != 8'hAD) emit(b1 == 8'hA0 ? 8'h20 : b1);
    end else if (b0 == 8'hC3) begin
      emit(b1 + 8'h40);
    end else if (b0 >= 8'hC4 && b0 <= 8'hC7) begin
      emit(ext_rows[b0[1:0]][b1[5:0]]);
    end else if (!(b0 == 8'hCC || (b0 == 8'hCD && b1 <= 8'hAF))) begin
      emit("?");
    end
  endfunction

  function automatic void fold_triple(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    logic [15:0] cp;
    cp = {b0[3:0], b1[5:0], b2[5:0]};
    if (b0 == 8'hE2 && b1 == 8'h80) begin
      case (b2)
        8'h8A, 8'hAF: emit(8'h20);
        8'h93: emit(8'h2D);
        8'h94: begin emit("-"); emit("-"); end
        8'h98: emit(8'h60);
        8'h99: emit(8'h27);
        8'h9C, 8'h9D: emit(8'h22);
        8'hA6: begin emit("."); emit("."); emit("."); end
        default: emit("?");
      endcase
    end else if (b0 == 8'hE2 && b1 == 8'h96) begin
      emit(b2 == 8'h88 ? "*" : "?");
    end else if (cp == 16'h2122) begin
      emit("T");
      emit("M");
    end else if (cp == 16'h00A0) begin
      emit(8'h20);
    end else if (cp >= 16'h0080 && cp <= 16'h00FF) begin
      emit(cp[7:0]);
    end else begin
      emit("?");
    end
  endfunction

  // Works out the results of one accepted byte and queues them.
  function automatic void predict_fold(logic [7:0] b, logic last, int typed_total);
    logic [7:0] buff[4];
    int n, need, k;
    bit raw;
    fold_res_t r;
    step_res.delete();
    for (k = 0; k < held_cnt; k++) buff[k] = held_bytes[k];
    buff[held_cnt] = b;
    n = held_cnt + 1;
    while (n > 0) begin
      raw = 1'b0;
      if ((buff[0] & 8'hF8) == 8'hF0) need = 4;
      else if ((buff[0] & 8'hF0) == 8'hE0) need = 3;
      else if ((buff[0] & 8'hE0) == 8'hC0 && buff[0] >= 8'hC2) need = 2;
      else need = 1;
      if (need > 1) begin
        for (k = 1; k < need && k < n; k++)
          if (buff[k][7:6] != 2'b10) raw = 1'b1;
        if (!raw && n < need) begin
          if (last) raw = 1'b1;
          else break;
        end
      end
      if (raw || need == 1) begin
        emit(buff[0]);
        need = 1;
      end else if (need == 4) begin
        emit("?");
      end else if (need == 3) begin
        fold_triple(buff[0], buff[1], buff[2]);
      end else begin
        fold_pair(buff[0], buff[1]);
      end
      for (k = 0; k + need < n; k++) buff[k] = buff[k + need];
      n -= need;
    end
    held_cnt = n;
    for (k = 0; k < n; k++) held_bytes[k] = buff[k];
    if (last) begin
      r = '{8'h00, 1'b0, 1'b0, 1'b1, written[CountW-1:0]};
      if (typed_total >= 0) r.total = typed_total[CountW-1:0];
      step_res.push_back(r);
      held_cnt = 0;
      written = 0;
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].run_end = 1'b1;
    foreach (step_res[k]) expected_out.push_back(step_res[k]);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last, int typed_total);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    is_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_fold(b, last, typed_total);
    items_sent++;
    if (last) strings_sent++;
  endtask

  task automatic write_capacity(logic [CountW-1:0] v);
    in_valid_i <= 1'b0;
    wait (expected_out.size() == 0);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_seq(ref logic [7:0] q[$]);
    logic [7:0] s[$];
    case ($urandom_range(0, 11))
      0: s = '{8'($urandom_range(0, 8'h7F))};
      1: s = '{8'hC2, 8'($urandom_range(8'h80, 8'hBF))};
      2: s = '{8'hC3, 8'($urandom_range(8'h80, 8'hBF))};
      3: s = '{8'($urandom_range(8'hC4, 8'hC7)), 8'($urandom_range(8'h80, 8'hBF))};
      4: s = '{8'($urandom_range(8'hCC, 8'hCD)), 8'($urandom_range(8'h80, 8'hBF))};
      5: s = '{8'hE2, 8'h80, 8'($urandom_range(8'h80, 8'hBF))};
      6: s = '{8'hE2, 8'h96, ($urandom_range(0, 1) ? 8'h88 : 8'($urandom_range(8'h80, 8'hBF)))};
      7: s = '{8'hE2, 8'h84, 8'hA2};
      8: s = '{8'($urandom_range(8'hE0, 8'hEF)), 8'($urandom_range(8'h80, 8'hBF)),
                8'($urandom_range(8'h80, 8'hBF))};
      9: s = '{8'($urandom_range(8'hF0, 8'hF7)), 8'($urandom_range(8'h80, 8'hBF)),
                8'($urandom_range(8'h80, 8'hBF)), 8'($urandom_range(8'h80, 8'hBF))};
      10: s = '{8'($urandom_range(8'hC0, 8'hDF)), 8'($urandom_range(8'h80, 8'hBF))};
      default: s = '{8'($urandom_range(0, 255))};
    endcase
    if (s.size() > 1 && $urandom_range(0, 7) == 0) void'(s.pop_back());
    foreach (s[k]) q.push_back(s[k]);
  endfunction

  dir_row_t dir_rows[] = '{
    '{8'h41, 1, 1, 1},
    '{8'h00, 0, 0, 0}, '{8'h7F, 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'h80, 1, 0, 0},
    '{8'hC2, 0, 0, 0}, '{8'hAD, 0, 0, 0}, '{8'hC2, 0, 0, 0}, '{8'hA0, 0, 0, 0},
    '{8'hC3, 0, 0, 0}, '{8'hBF, 0, 0, 0}, '{8'hC7, 0, 0, 0}, '{8'hBF, 0, 0, 0},
    '{8'hCC, 0, 0, 0}, '{8'h80, 0, 0, 0}, '{8'hCD, 0, 0, 0}, '{8'hB0, 1, 0, 0},
    '{8'hE2, 0, 0, 0}, '{8'h80, 0, 0, 0}, '{8'h94, 0, 0, 0},
    '{8'hE2, 0, 0, 0}, '{8'h84, 0, 0, 0}, '{8'hA2, 0, 0, 0},
    '{8'hE2, 0, 0, 0}, '{8'h41, 1, 0, 0},
    '{8'hF0, 0, 0, 0}, '{8'h9F, 0, 0, 0}, '{8'h98, 0, 0, 0}, '{8'h80, 1, 1, 1},
    '{8'hC3, 1, 1, 1}};

  always @(posedge clk_i) begin
    fold_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte=%h has=%b end=%b/%b total=%0d", $time,
                 out_byte_o, has_byte_o, run_end_o, string_end_o, total_written_o);
      end else begin
        e = expected_out.pop_front();
        if (e.ch !== out_byte_o || e.has !== has_byte_o || e.run_end !== run_end_o ||
            e.str_end !== string_end_o || e.total !== total_written_o) begin
          errors++;
          $display("%0t: mismatch expected byte=%h has=%b end=%b/%b total=%0d", $time,
                   e.ch, e.has, e.run_end, e.str_end, e.total);
          $display("%0t:          actual byte=%h has=%b end=%b/%b total=%0d", $time,
                   out_byte_o, has_byte_o, run_end_o, string_end_o, total_written_o);
        end
      end
    end
  end

  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (80) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [7:0] str_q[$];
    logic [CountW-1:0] caps[];
    int rand_items;
    int phase;
    caps = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65535};
    held_cnt = 0;
    written = 0;
    capacity = 16'hFFFF;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k])
      send_byte(dir_rows[k].ch, dir_rows[k].last,
                dir_rows[k].typed ? dir_rows[k].total : -1);

    rand_items = 0;
    phase = 0;
    while (rand_items < 320) begin
      if (rand_items >= phase * 50) begin
        if (phase < caps.size()) write_capacity(caps[phase]);
        else if (phase % 2) write_capacity(16'($urandom_range(0, 20)));
        else write_capacity(16'($urandom_range(0, 16'hFFFF)));
        phase++;
      end
      if (rand_items >= 100 && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (rand_items >= 280) quiet = 1'b1;
      str_q.delete();
      repeat ($urandom_range(1, 6)) add_seq(str_q);
      foreach (str_q[k]) send_byte(str_q[k], k == str_q.size() - 1, -1);
      rand_items += str_q.size();
    end
    in_valid_i <= 1'b0;
    wait (expected_out.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d bytes in %0d strings, %0d results checked, %0d capacity settings.",
             items_sent, strings_sent, results_seen, phase + 1);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
